FILE: sv/rtwa_pkg.sv
`timescale 1ns / 1ps

package rtwa_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int WORD_W = 32;
  localparam int HOPS_W = 8;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W = 4;
  localparam int IN_DATA_W = 5 * WORD_W + HOPS_W;
  localparam int OUT_DATA_W = 8;
  localparam logic [WORD_W-1:0] TIMEOUT_RESET = 32'd10;

  // slot layout: destination, start time, next hop, sequence, hops from the lowest bit up
  localparam int ENTRY_W = 4 * WORD_W + HOPS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

endpackage

FILE: sv/rtwa_ram.sv
`timescale 1ns / 1ps

module rtwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/route_table_with_aging.sv
`timescale 1ns / 1ps

// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser command, tdata route fields
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser status, tdata slot index
// max_age   in         max_age_we                     max_age_wdata
//
// one command at a time: after the input transfer the SCAN state reads every slot, FINISH
// registers the result, and only then is the next command taken in IDLE
// the single read port of the slot memory walks every slot for aging and matching
// rst clears the valid bits, the timeout (to 10) and m_axis_tvalid, and returns to IDLE; no clearing pass
// the result register frees the input side; a stalled result holds the final cycle

module route_table_with_aging #(
  parameter int TABLE_DEPTH = rtwa_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // now, destination, gateway_addr, start_time, dest_sequence, hop_count
  input  logic [rtwa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [rtwa_pkg::CMD_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // slot_index, zero padded
  output logic [rtwa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [rtwa_pkg::STATUS_W-1:0]   m_axis_tuser,
  input  logic                            max_age_we,
  input  logic [rtwa_pkg::WORD_W-1:0]     max_age_wdata
);

  import rtwa_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  state_t state, state_next;

  logic [WORD_W-1:0] max_age;
  logic [TABLE_DEPTH-1:0] vld;

  logic [CMD_W-1:0]  cmd;
  logic [WORD_W-1:0] now;
  logic [WORD_W-1:0] dest;
  logic [WORD_W-1:0] gateway;
  logic [WORD_W-1:0] start_time;
  logic [WORD_W-1:0] sequence_num;
  logic [HOPS_W-1:0] hops;

  logic [CW-1:0] rd_cnt;
  logic          chk_vld;
  logic [IW-1:0] chk_idx;
  logic          match_found;
  logic [IW-1:0] match_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;

  logic              ram_re;
  logic              ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic              in_xfer;
  logic              out_free;
  logic              finish_go;
  logic [WORD_W-1:0] age;
  logic              slot_live;
  logic              slot_aged;
  logic              slot_hit;
  logic              take_match;
  logic              take_free;
  logic              drop_match;
  logic              is_put;
  status_t           res_status;
  logic [IW-1:0]     res_idx;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign is_put   = (cmd == CMD_PUT);

  rtwa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {hops, sequence_num, gateway, start_time, dest};

  // per-slot aging and matching on the data just read
  always_comb begin
    age        = now - ram_rdata[2*WORD_W-1:WORD_W];
    slot_aged  = vld[chk_idx] && !age[WORD_W-1] && (age > max_age);
    slot_live  = vld[chk_idx] && !slot_aged;
    slot_hit   = slot_live && (ram_rdata[WORD_W-1:0] == dest);
    take_match = chk_vld && slot_hit && !match_found;
    drop_match = take_match && (is_put || cmd == CMD_REMOVE);
    take_free  = chk_vld && !free_found && (!slot_live || (take_match && is_put));
  end

  // result selection
  always_comb begin
    res_status = STATUS_NOT_FOUND;
    res_idx    = '0;
    case (cmd)
      CMD_PUT: begin
        if (free_found) begin
          res_status = STATUS_OK;
          res_idx    = free_idx;
        end else begin
          res_status = STATUS_FULL;
        end
      end
      CMD_GET, CMD_REMOVE: begin
        if (match_found) begin
          res_status = STATUS_OK;
          res_idx    = match_idx;
        end
      end
      default: begin
        res_status = STATUS_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (in_xfer) begin
          state_next = SCAN;
        end
      end
      SCAN: begin
        if (chk_vld && chk_idx == LAST_IDX) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (out_free) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    finish_go     = 1'b0;
    ram_we        = 1'b0;
    case (state)
      IDLE: begin
        s_axis_tready = 1'b1;
      end
      SCAN: begin
        ram_re = (rd_cnt < DEPTH_CNT);
      end
      FINISH: begin
        finish_go = out_free;
        ram_we    = out_free && is_put && free_found;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      max_age       <= TIMEOUT_RESET;
      vld           <= '0;
      rd_cnt        <= '0;
      chk_vld       <= 1'b0;
      match_found   <= 1'b0;
      free_found    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (max_age_we) begin
        max_age <= max_age_wdata;
      end
      if (in_xfer) begin
        rd_cnt      <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end
      if (ram_re) begin
        rd_cnt <= rd_cnt + CW'(1);
      end
      chk_vld <= ram_re;
      if (chk_vld && (slot_aged || drop_match)) begin
        vld[chk_idx] <= 1'b0;
      end
      if (take_match) begin
        match_found <= 1'b1;
      end
      if (take_free) begin
        free_found <= 1'b1;
      end
      if (ram_we) begin
        vld[free_idx] <= 1'b1;
      end
      if (finish_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd          <= s_axis_tuser;
      now          <= s_axis_tdata[WORD_W-1:0];
      dest         <= s_axis_tdata[2*WORD_W-1:WORD_W];
      gateway      <= s_axis_tdata[3*WORD_W-1:2*WORD_W];
      start_time   <= s_axis_tdata[4*WORD_W-1:3*WORD_W];
      sequence_num <= s_axis_tdata[5*WORD_W-1:4*WORD_W];
      hops         <= s_axis_tdata[5*WORD_W+HOPS_W-1:5*WORD_W];
    end
    chk_idx <= rd_cnt[IW-1:0];
    if (take_match) begin
      match_idx <= chk_idx;
    end
    if (take_free) begin
      free_idx <= chk_idx;
    end
    if (finish_go) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= OUT_DATA_W'(SLOT_W'(res_idx));
    end
  end

endmodule

FILE: dv/route_table_with_aging_tb.sv
`timescale 1ns / 1ps

module route_table_with_aging_tb;
  import rtwa_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int POOL_SIZE = 24;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 172;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  // packed so that now lands in the lowest bits of tdata
  typedef struct packed {
    logic [HOPS_W-1:0] hop_count;
    logic [WORD_W-1:0] dest_sequence;
    logic [WORD_W-1:0] start_time;
    logic [WORD_W-1:0] gateway_addr;
    logic [WORD_W-1:0] destination;
    logic [WORD_W-1:0] now;
  } route_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } route_reply_t;

  class route_table_shadow;
    logic [WORD_W-1:0] timeout;
    bit                slot_live[DEPTH];
    logic [WORD_W-1:0] slot_dest[DEPTH];
    logic [WORD_W-1:0] slot_born[DEPTH];
    route_reply_t      pending_replies[$];
    int                mismatches;
    int                cmd_count[4];
    int                status_count[4];

    function new();
      timeout = TIMEOUT_RESET;
      mismatches = 0;
      foreach (slot_live[k]) slot_live[k] = 1'b0;
      foreach (cmd_count[k]) cmd_count[k] = 0;
      foreach (status_count[k]) status_count[k] = 0;
    endfunction

    function void set_timeout(logic [WORD_W-1:0] value);
      timeout = value;
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, route_cmd_t c);
      logic [WORD_W-1:0] diff;
      longint            age;
      longint            limit;
      int                hit;
      int                free_slot;
      route_reply_t      reply;
      limit = {32'd0, timeout};
      cmd_count[cmd]++;
      for (int k = 0; k < DEPTH; k++) begin
        if (slot_live[k]) begin
          diff = c.now - slot_born[k];
          age = longint'($signed(diff));
          if (age > limit) slot_live[k] = 1'b0;
        end
      end
      hit = -1;
      for (int k = DEPTH - 1; k >= 0; k--)
        if (slot_live[k] && slot_dest[k] == c.destination) hit = k;
      reply.status = STATUS_NOT_FOUND;
      reply.slot = '0;
      case (cmd)
        CMD_PUT: begin
          if (hit >= 0) slot_live[hit] = 1'b0;
          free_slot = -1;
          for (int k = DEPTH - 1; k >= 0; k--)
            if (!slot_live[k]) free_slot = k;
          if (free_slot >= 0) begin
            slot_live[free_slot] = 1'b1;
            slot_dest[free_slot] = c.destination;
            slot_born[free_slot] = c.start_time;
            reply.status = STATUS_OK;
            reply.slot = free_slot[SLOT_W-1:0];
          end else begin
            reply.status = STATUS_FULL;
          end
        end
        CMD_GET, CMD_REMOVE: begin
          if (hit >= 0) begin
            if (cmd == CMD_REMOVE) slot_live[hit] = 1'b0;
            reply.status = STATUS_OK;
            reply.slot = hit[SLOT_W-1:0];
          end
        end
        default: begin
        end
      endcase
      pending_replies.push_back(reply);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [OUT_DATA_W-1:0] data);
      route_reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected reply, status %0d tdata %0h", $time, status, data);
        return;
      end
      want = pending_replies.pop_front();
      status_count[status]++;
      if (status !== want.status || data !== {{(OUT_DATA_W-SLOT_W){1'b0}}, want.slot}) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: reply mismatch, expected status %0d slot %0d, got status %0d tdata %0h",
                   $time, want.status, want.slot, status, data);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  max_age_we;
  logic [WORD_W-1:0]     max_age_wdata;

  route_table_shadow shadow;
  logic [WORD_W-1:0] dest_pool[POOL_SIZE];
  logic [WORD_W-1:0] clock_base;
  logic [WORD_W-1:0] phase_timeouts[PHASES];
  route_cmd_t        extreme_cmd;
  bit                steady_flow;
  bit                hold_request;
  int                holds_done;
  int                timeout_writes;
  int                stall_count;

  route_table_with_aging #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .max_age_we    (max_age_we),
    .max_age_wdata (max_age_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_route(logic [CMD_W-1:0] cmd, route_cmd_t c);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    shadow.note_command(cmd, c);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    int n;
    n = gap_len();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_fixed(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] now,
                            logic [WORD_W-1:0] dest, logic [WORD_W-1:0] start);
    route_cmd_t c;
    c.now = now;
    c.destination = dest;
    c.start_time = start;
    c.gateway_addr = $urandom();
    c.dest_sequence = $urandom();
    c.hop_count = HOPS_W'($urandom_range(0, 255));
    send_route(cmd, c);
    pause_sender();
  endtask

  task automatic send_random_route();
    route_cmd_t       c;
    logic [CMD_W-1:0] cmd;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 45) cmd = CMD_PUT;
    else if (r < 75) cmd = CMD_GET;
    else if (r < 95) cmd = CMD_REMOVE;
    else cmd = CMD_UNUSED;
    if ($urandom_range(0, 49) == 0) clock_base = $urandom();
    else clock_base += $urandom_range(0, 3);
    c.now = clock_base;
    if ($urandom_range(0, 9) == 0) c.destination = $urandom();
    else c.destination = dest_pool[$urandom_range(0, POOL_SIZE - 1)];
    r = $urandom_range(0, 9);
    if (r < 8) c.start_time = clock_base - $urandom_range(0, 20);
    else if (r == 8) c.start_time = clock_base + $urandom_range(1, 20);
    else c.start_time = $urandom();
    c.gateway_addr = $urandom();
    c.dest_sequence = $urandom();
    c.hop_count = HOPS_W'($urandom_range(0, 255));
    send_route(cmd, c);
    pause_sender();
  endtask

  // lowers valid and holds the sender back until every reply is in
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (shadow.outstanding() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_timeout(logic [WORD_W-1:0] value);
    max_age_we <= 1'b1;
    max_age_wdata <= value;
    @(negedge clk);
    max_age_we <= 1'b0;
    shadow.set_timeout(value);
    timeout_writes++;
    @(negedge clk);
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    int n;
    @(posedge clk iff !rst);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
        hold_request = 1'b0;
        holds_done++;
        @(negedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          m_axis_tready <= 1'b0;
          repeat (n) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      shadow.check_reply(m_axis_tuser, m_axis_tdata);
  end

  initial begin
    stall_count = 0;
    while (stall_count < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_count = 0;
      else
        stall_count++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [WORD_W-1:0] t0;
    shadow = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    max_age_we = 1'b0;
    max_age_wdata = '0;
    steady_flow = 1'b0;
    hold_request = 1'b0;
    holds_done = 0;
    timeout_writes = 0;
    clock_base = 32'd1000;
    dest_pool[0] = 32'h0000_0000;
    dest_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < POOL_SIZE; k++) dest_pool[k] = $urandom();
    phase_timeouts = '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'd30, 32'd20, 32'd10};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, unused command, extreme fields, replace, full table,
    // aging across the wrap of now, and an entry stamped in the future
    t0 = 32'hFFFF_FFF8;
    send_fixed(CMD_GET, 32'h0000_0000, 32'd5, 32'd0);
    send_fixed(CMD_REMOVE, 32'hFFFF_FFFF, 32'd5, 32'd0);
    send_fixed(CMD_UNUSED, t0, 32'd5, 32'd0);
    extreme_cmd = '0;
    extreme_cmd.now = t0;
    extreme_cmd.start_time = t0;
    send_route(CMD_PUT, extreme_cmd);
    extreme_cmd = '1;
    extreme_cmd.now = t0;
    extreme_cmd.start_time = t0;
    send_route(CMD_PUT, extreme_cmd);
    send_fixed(CMD_GET, t0, 32'hFFFF_FFFF, 32'd0);
    send_fixed(CMD_PUT, t0, 32'h0000_0000, t0);
    send_fixed(CMD_REMOVE, t0, 32'h0000_0000, 32'd0);
    send_fixed(CMD_GET, t0, 32'h0000_0000, 32'd0);
    send_fixed(CMD_PUT, t0, 32'hA5A5_5A5A, t0 + 32'd40);
    for (int k = 0; k < DEPTH - 2; k++) send_fixed(CMD_PUT, t0, 32'h100 + k, t0);
    send_fixed(CMD_PUT, t0, 32'h200, t0);
    send_fixed(CMD_GET, 32'd4, 32'h100, 32'd0);
    send_fixed(CMD_GET, 32'd4, 32'hA5A5_5A5A, 32'd0);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == 6) write_timeout($urandom_range(1, 60));
      else write_timeout(phase_timeouts[p]);
      steady_flow = (p == 5);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 3 && i == 40) hold_request = 1'b1;
        send_random_route();
      end
    end
    steady_flow = 1'b0;
    wait_drained();
    repeat (DEPTH + 8) @(negedge clk);

    $display("covered %0d put, %0d get, %0d remove, %0d unused commands over %0d timeouts",
             shadow.cmd_count[CMD_PUT], shadow.cmd_count[CMD_GET],
             shadow.cmd_count[CMD_REMOVE], shadow.cmd_count[CMD_UNUSED], timeout_writes);
    $display("replies: %0d ok, %0d table full, %0d not found; %0d long receiver hold-offs",
             shadow.status_count[STATUS_OK], shadow.status_count[STATUS_FULL],
             shadow.status_count[STATUS_NOT_FOUND], holds_done);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d replies missing", shadow.mismatches, shadow.outstanding());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
